>>> hw/rtl/vpd_pkg.sv
// Shared types and constants of the video packet deframer.
package vpd_pkg;

    localparam int PAYLOAD_WORDS = 80;
    localparam int MAX_PACKETS   = 60;
    localparam int MAX_SEGMENTS  = 4;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [6:0]  LAST_POS       = 7'(PAYLOAD_WORDS + 1);
    localparam logic [3:0]  DISCARD_NIBBLE = 4'hf;
    localparam logic [11:0] CHECK_PACKET   = 12'd20;
    localparam logic [5:0]  PACKETS_RESET  = 6'd60;
    localparam logic [2:0]  SEGMENTS_RESET = 3'd4;

    typedef enum logic {
        REG_PACKETS  = 1'b0,
        REG_SEGMENTS = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_PKT_ERR = 2'd1,
        KIND_SEG_ERR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [5:0] packets_per_segment;
        logic [2:0] segments_per_frame;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] data_word;
        logic [14:0] word_address;
        logic        frame_end;
    } result_t;

endpackage

>>> hw/rtl/video_packet_deframer.sv
// Top level of the video packet deframer: config registers, front end and result queue.
//
// s_ channel: one 16-bit stream word per item, packets of ID, CRC and 80 payload words.
// m_ channel: one result per payload word, or one error item on a rejected packet ID.
//   m_tuser carries the kind (payload, packet number error, segment number error),
//   m_tdata the payload word and its frame word address, m_tlast the frame end.
// Config (APB): 0x0 packets per segment, 0x4 segments per frame; write only while idle.
// A result reaches m_ in the cycle after its word is accepted when the queue is empty.
// Throughput: one word per cycle while s_tready is high; the front end checks and
//   addresses each word combinationally and the result queue takes one item per cycle.
// When the receiver stalls, the queue absorbs up to QUEUE_DEPTH results, then s_tready
//   drops until space frees up. No item is dropped or repeated.
// Reset: registers return to 60 packets and 4 segments, the queue empties and the block
//   expects packet 0 of segment 1 at the next word.
module video_packet_deframer #(
    parameter int QUEUE_DEPTH = vpd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] stream_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] data_word, [30:16] word_address, [31] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // frame_end
);
    import vpd_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t reg_sel;
    logic       cfg_write;
    logic       queue_full;
    logic       push;
    result_t    push_item;
    result_t    head_item;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.packets_per_segment <= PACKETS_RESET;
            cfg_reg.segments_per_frame  <= SEGMENTS_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_PACKETS:  cfg_reg.packets_per_segment <= pwdata[5:0];
                REG_SEGMENTS: cfg_reg.segments_per_frame  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_PACKETS:  prdata = 32'(cfg_reg.packets_per_segment);
            REG_SEGMENTS: prdata = 32'(cfg_reg.segments_per_frame);
            default:      prdata = 32'd0;
        endcase
    end

    assign s_tready = !queue_full;

    vpd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_word   (s_tdata),
        .in_ready  (s_tready),
        .push      (push),
        .push_item (push_item)
    );

    vpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .head_valid (m_tvalid),
        .head_item  (head_item),
        .pop_ready  (m_tready)
    );

    assign m_tdata = {1'b0, head_item.word_address, head_item.data_word};
    assign m_tuser = head_item.kind;
    assign m_tlast = head_item.frame_end;

endmodule

>>> hw/rtl/vpd_front.sv
// Front end: tracks packet position, checks IDs and builds result items.
module vpd_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  vpd_pkg::cfg_t    cfg,
    input  logic             in_valid,
    input  logic [15:0]      in_word,
    input  logic             in_ready,
    output logic             push,
    output vpd_pkg::result_t push_item
);
    import vpd_pkg::*;

    logic [6:0]  pos_reg, pos_next;
    logic [5:0]  pkt_reg, pkt_next;
    logic [2:0]  seg_reg, seg_next;
    logic        skip_reg, skip_next;
    logic        rep_reg, rep_next;
    logic [14:0] addr_reg, addr_next;

    logic [6:0]  eff_p;
    logic [2:0]  eff_s;
    logic [2:0]  seg0;
    logic [9:0]  seg_base;
    logic [10:0] pkt_linear;
    logic [17:0] base_full;
    logic        accept;

    assign accept = in_valid && in_ready;

    always_comb begin
        if (cfg.packets_per_segment == 6'd0) begin
            eff_p = 7'd1;
        end else if (7'(cfg.packets_per_segment) > 7'(MAX_PACKETS)) begin
            eff_p = 7'(MAX_PACKETS);
        end else begin
            eff_p = 7'(cfg.packets_per_segment);
        end
        if (cfg.segments_per_frame == 3'd0) begin
            eff_s = 3'd1;
        end else if (cfg.segments_per_frame > 3'(MAX_SEGMENTS)) begin
            eff_s = 3'(MAX_SEGMENTS);
        end else begin
            eff_s = cfg.segments_per_frame;
        end
    end

    assign seg0       = seg_reg - 3'd1;
    assign seg_base   = 10'(seg0) * 10'(eff_p);
    assign pkt_linear = 11'(seg_base) + 11'(pkt_reg);
    assign base_full  = 18'(pkt_linear) * 18'(PAYLOAD_WORDS);

    always_comb begin
        pos_next  = pos_reg;
        pkt_next  = pkt_reg;
        seg_next  = seg_reg;
        skip_next = skip_reg;
        rep_next  = rep_reg;
        addr_next = addr_reg;
        push      = 1'b0;
        push_item = '{kind: KIND_PAYLOAD, data_word: 16'd0, word_address: 15'd0,
                      frame_end: 1'b0};
        if (accept) begin
            pos_next = (pos_reg >= LAST_POS) ? 7'd0 : pos_reg + 7'd1;
            if (pos_reg == 7'd0) begin
                skip_next = 1'b0;
                if (in_word[11:8] == DISCARD_NIBBLE) begin
                    skip_next = 1'b1;
                end else begin
                    priority if (in_word[11:0] != 12'(pkt_reg)) begin
                        push           = 1'b1;
                        push_item.kind = KIND_PKT_ERR;
                    end else if (in_word[11:0] == CHECK_PACKET &&
                                 in_word[14:12] != 3'd0 &&
                                 in_word[14:12] != seg_reg) begin
                        push           = 1'b1;
                        push_item.kind = KIND_SEG_ERR;
                    end else begin
                        if (in_word[11:0] == CHECK_PACKET && in_word[14:12] == 3'd0) begin
                            rep_next = 1'b1;
                        end
                        addr_next = base_full[14:0];
                    end
                    if (push) begin
                        pkt_next  = 6'd0;
                        seg_next  = 3'd1;
                        rep_next  = 1'b0;
                        skip_next = 1'b1;
                    end
                end
            end else if (pos_reg >= 7'd2 && !skip_reg) begin
                push                   = 1'b1;
                push_item.data_word    = in_word;
                push_item.word_address = addr_reg;
                addr_next              = addr_reg + 15'd1;
                if (pos_reg >= LAST_POS) begin
                    if (7'(pkt_reg) + 7'd1 >= eff_p) begin
                        pkt_next = 6'd0;
                        if (rep_reg) begin
                            rep_next = 1'b0;
                        end else if (seg_reg >= eff_s) begin
                            seg_next            = 3'd1;
                            push_item.frame_end = 1'b1;
                        end else begin
                            seg_next = seg_reg + 3'd1;
                        end
                    end else begin
                        pkt_next = pkt_reg + 6'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 7'd0;
            pkt_reg  <= 6'd0;
            seg_reg  <= 3'd1;
            skip_reg <= 1'b0;
            rep_reg  <= 1'b0;
            addr_reg <= 15'd0;
        end else begin
            pos_reg  <= pos_next;
            pkt_reg  <= pkt_next;
            seg_reg  <= seg_next;
            skip_reg <= skip_next;
            rep_reg  <= rep_next;
            addr_reg <= addr_next;
        end
    end

endmodule

>>> hw/rtl/vpd_queue.sv
// Back end: short result queue whose head drives the output channel.
module vpd_queue #(
    parameter int DEPTH = vpd_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  vpd_pkg::result_t push_item,
    output logic             full,
    output logic             head_valid,
    output vpd_pkg::result_t head_item,
    input  logic             pop_ready
);
    import vpd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pop;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem_reg[rd_reg];
    assign pop        = head_valid && pop_ready;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

>>> bench/vpd_tb_pkg.sv
// Expected-result tracking for the video packet deframer bench: stream state and result checking.
package vpd_tb_pkg;

    import vpd_pkg::*;

    class deframer_model;
        logic [5:0]  cfg_packets;
        logic [2:0]  cfg_segments;
        logic [6:0]  word_pos;
        logic [5:0]  pkt_idx;
        logic [2:0]  seg_num;
        bit          skipping;
        bit          repeat_seg;
        logic [14:0] next_addr;
        result_t     expected_results[$];
        int          mismatches;
        int          payload_count;
        int          pkt_err_count;
        int          seg_err_count;
        int          frame_count;

        function new();
            cfg_packets  = PACKETS_RESET;
            cfg_segments = SEGMENTS_RESET;
            word_pos     = '0;
            pkt_idx      = '0;
            seg_num      = 3'd1;
            skipping     = 1'b0;
            repeat_seg   = 1'b0;
            next_addr    = '0;
        endfunction

        function void write_reg(reg_index_t idx, logic [31:0] value);
            case (idx)
                REG_PACKETS: begin
                    cfg_packets = value[5:0];
                end
                REG_SEGMENTS: begin
                    cfg_segments = value[2:0];
                end
                default: ;
            endcase
        endfunction

        function int packets_used();
            int p;
            p = int'(cfg_packets);
            if (p < 1) p = 1;
            if (p > MAX_PACKETS) p = MAX_PACKETS;
            return p;
        endfunction

        function int segments_used();
            int s;
            s = int'(cfg_segments);
            if (s < 1) s = 1;
            if (s > MAX_SEGMENTS) s = MAX_SEGMENTS;
            return s;
        endfunction

        // Advances the stream state by one word; returns 1 when the word yields a result.
        function bit predict_word(input logic [15:0] w, output result_t r);
            logic [6:0] pos;
            kind_t      err;
            bit         has;
            int         base;
            pos = word_pos;
            r   = '0;
            has = 1'b0;
            if (pos == 7'd0) begin
                skipping = 1'b0;
                if (w[11:8] == DISCARD_NIBBLE) begin
                    skipping = 1'b1;
                end else begin
                    err = KIND_PAYLOAD;
                    if (w[11:0] != 12'(pkt_idx)) begin
                        err = KIND_PKT_ERR;
                    end else if (w[11:0] == CHECK_PACKET) begin
                        if (w[14:12] == 3'd0) repeat_seg = 1'b1;
                        else if (w[14:12] != seg_num) err = KIND_SEG_ERR;
                    end
                    if (err != KIND_PAYLOAD) begin
                        r.kind     = err;
                        has        = 1'b1;
                        pkt_idx    = '0;
                        seg_num    = 3'd1;
                        repeat_seg = 1'b0;
                        skipping   = 1'b1;
                    end else begin
                        base      = ((int'(seg_num) - 1) & 7) * packets_used() + int'(pkt_idx);
                        next_addr = 15'(base * PAYLOAD_WORDS);
                    end
                end
            end else if (pos >= 7'd2 && !skipping) begin
                r.kind         = KIND_PAYLOAD;
                r.data_word    = w;
                r.word_address = next_addr;
                next_addr      = next_addr + 15'd1;
                if (pos >= LAST_POS) begin
                    if (int'(pkt_idx) + 1 >= packets_used()) begin
                        pkt_idx = '0;
                        if (repeat_seg) begin
                            repeat_seg = 1'b0;
                        end else if (int'(seg_num) >= segments_used()) begin
                            seg_num     = 3'd1;
                            r.frame_end = 1'b1;
                        end else begin
                            seg_num = seg_num + 3'd1;
                        end
                    end else begin
                        pkt_idx = pkt_idx + 6'd1;
                    end
                end
                has = 1'b1;
            end
            word_pos = (pos >= LAST_POS) ? 7'd0 : pos + 7'd1;
            return has;
        endfunction

        function void note_word(logic [15:0] w);
            result_t r;
            if (predict_word(w, r)) expected_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d data %h address %0d frame_end %0b",
                       got.kind, got.data_word, got.word_address, got.frame_end);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.data_word !== want.data_word) begin
                $error("data_word: expected %h, got %h", want.data_word, got.data_word);
                mismatches++;
            end
            if (got.word_address !== want.word_address) begin
                $error("word_address: expected %0d, got %0d", want.word_address,
                       got.word_address);
                mismatches++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
                mismatches++;
            end
            case (want.kind)
                KIND_PAYLOAD: payload_count++;
                KIND_PKT_ERR: pkt_err_count++;
                KIND_SEG_ERR: seg_err_count++;
                default: ;
            endcase
            if (want.frame_end) frame_count++;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

>>> bench/tb_video_packet_deframer.sv
// Self-checking bench of the video packet deframer: packet streams, register phases, stalls.
module tb_video_packet_deframer;

    timeunit 1ns;
    timeprecision 1ps;

    import vpd_pkg::*;
    import vpd_tb_pkg::*;

    typedef enum int {
        ID_GOOD,
        ID_REPEAT,
        ID_BAD_NUM,
        ID_BAD_SEG,
        ID_DISCARD
    } id_style_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [15:0] stream_word
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [15:0] data_word, [30:16] word_address, [31] zero
    logic [1:0]  m_tuser;        // [1:0] kind
    logic        m_tlast;        // frame_end

    deframer_model sb;       // tracks accepted words, checks results
    deframer_model shadow;   // runs ahead of the stream to build well-formed packets
    bit            tx_no_gaps;
    int            words_sent;
    int            words_taken;
    int            results_taken;
    result_t       got;

    video_packet_deframer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_id(id_style_t st);
        logic [15:0] w;
        logic [2:0]  s;
        w = 16'($urandom);
        case (st)
            ID_GOOD: begin
                w[11:0] = 12'(shadow.pkt_idx);
                if (w[11:0] == CHECK_PACKET) w[14:12] = shadow.seg_num;
            end
            ID_REPEAT: begin
                w[11:0]  = 12'(shadow.pkt_idx);
                w[14:12] = 3'd0;
            end
            ID_BAD_NUM: begin
                if ($urandom_range(0, 1) == 0) w[11:0] = 12'(shadow.pkt_idx) + 12'd1;
                while (w[11:8] == DISCARD_NIBBLE || w[11:0] == 12'(shadow.pkt_idx))
                    w = 16'($urandom);
            end
            ID_BAD_SEG: begin
                w[11:0] = 12'(shadow.pkt_idx);
                do s = 3'($urandom_range(1, 7)); while (s == shadow.seg_num);
                w[14:12] = s;
            end
            ID_DISCARD: begin
                w[11:8] = DISCARD_NIBBLE;
            end
            default: ;
        endcase
        return w;
    endfunction

    // Sends one whole packet: ID word, CRC word, payload. Entered and left at a falling edge.
    task automatic send_packet(input logic [15:0] id);
        logic [15:0] w;
        result_t     scratch;
        int          gap;
        for (int i = 0; i < PAYLOAD_WORDS + 2; i++) begin
            if (i == 0) begin
                w = id;
            end else begin
                case ($urandom_range(0, 7))
                    0: w = 16'h0000;
                    1: w = 16'hffff;
                    default: w = 16'($urandom);
                endcase
            end
            void'(shadow.predict_word(w, scratch));
            gap = tx_no_gaps ? 0 : pick_gap();
            repeat (gap) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
            s_tvalid = 1'b1;
            s_tdata  = w;
            do @(posedge aclk); while (!s_tready);
            words_sent++;
            @(negedge aclk);
        end
    endtask

    // Waits until every expected result has arrived and the block has gone quiet.
    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_reg(input reg_index_t idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(idx, value);
        shadow.write_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_word(s_tdata);
                words_taken++;
            end
            if (m_tvalid && m_tready) begin
                got.kind         = kind_t'(m_tuser);
                got.data_word    = m_tdata[15:0];
                got.word_address = m_tdata[30:16];
                got.frame_end    = m_tlast;
                sb.check_result(got);
                results_taken++;
            end
        end
    end

    // Result side: random stalls, quiet stretches, and a long hold-off now and then.
    initial begin
        int stall_left;
        int quiet_left;
        int hold_left;
        int next_hold_at;
        int r;
        stall_left   = 0;
        quiet_left   = 0;
        hold_left    = 0;
        next_hold_at = 200;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (results_taken >= next_hold_at) begin
                m_tready     = 1'b0;
                hold_left    = 79;
                next_hold_at = next_hold_at + 2500;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (quiet_left > 0) begin
                    quiet_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 2) quiet_left = $urandom_range(100, 300);
                    else if (r < 25) stall_left = pick_gap();
                end
            end
        end
    end

    initial begin
        int        rand_start;
        int        r;
        id_style_t st;
        sb            = new();
        shadow        = new();
        tx_no_gaps    = 1'b0;
        words_sent    = 0;
        words_taken   = 0;
        results_taken = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset registers: packet 0, discards, errors in a row, recovery
        send_packet(16'h8000);
        send_packet(16'hffff);
        send_packet(16'h0f00);
        send_packet(pick_id(ID_GOOD));
        send_packet(16'h7eff);
        send_packet(pick_id(ID_BAD_NUM));
        send_packet(pick_id(ID_GOOD));

        // clamped counts at both ends
        settle();
        set_reg(REG_PACKETS, 32'd0);
        set_reg(REG_SEGMENTS, 32'd0);
        send_packet(pick_id(ID_GOOD));
        send_packet(pick_id(ID_GOOD));
        settle();
        set_reg(REG_PACKETS, 32'h3f);
        set_reg(REG_SEGMENTS, 32'd7);
        send_packet(pick_id(ID_GOOD));

        // random phase; counts may drop below the current index mid-frame
        rand_start = words_sent;
        while (words_sent - rand_start < 80) begin
            settle();
            if ($urandom_range(0, 9) < 6) set_reg(REG_PACKETS, $urandom_range(0, 4));
            else set_reg(REG_PACKETS, $urandom_range(21, 63));
            set_reg(REG_SEGMENTS, $urandom_range(0, 7));
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4)) begin
                r = $urandom_range(0, 99);
                if (r < 75) st = ID_GOOD;
                else if (r < 83) st = ID_DISCARD;
                else if (r < 90) st = ID_BAD_NUM;
                else if (r < 95) st = ID_BAD_SEG;
                else st = ID_REPEAT;
                send_packet(pick_id(st));
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d stream words and %0d results under several register settings.",
                 words_taken, results_taken);
        $display("Results: %0d payload, %0d packet number errors, %0d segment errors,",
                 sb.payload_count, sb.pkt_err_count, sb.seg_err_count);
        $display("         %0d frame ends.", sb.frame_count);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/vpd_pkg.sv
hw/rtl/vpd_front.sv
hw/rtl/vpd_queue.sv
hw/rtl/video_packet_deframer.sv
bench/vpd_tb_pkg.sv
bench/tb_video_packet_deframer.sv
